@@ src/pfba_pkg.sv @@
package pfba_pkg;

	// Bitmap word geometry: one bit per page frame.
	localparam int BITS_PER_WORD = 8;
	localparam int BIT_W = $clog2(BITS_PER_WORD);

	// Page geometry and byte address width.
	localparam int PAGE_BYTES = 4096;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int ADDR_W = 32;

	// Page count register.
	localparam int COUNT_W = 13;
	localparam logic [COUNT_W-1:0] PAGE_COUNT_RESET = COUNT_W'(4096);

	// Default size of the managed frame space.
	localparam int MAX_PAGES_DEFAULT = 4096;

	typedef logic [BITS_PER_WORD-1:0] word_t;

endpackage

@@ src/pfba_bitmap_ram.sv @@
module pfba_bitmap_ram #(
	parameter int DEPTH = 512,
	parameter int AW = 9
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  pfba_pkg::word_t     wdata,
	input  logic                re,
	input  logic [AW-1:0]       raddr,
	output pfba_pkg::word_t     rdata
);

	pfba_pkg::word_t mem [DEPTH];
	pfba_pkg::word_t rdata_q;

	// Single write port, single registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/page_frame_bitmap_allocator_top.sv @@
// A request is taken in ST_IDLE, its frame range is set up in ST_PREP, and then k bitmap words are
// visited (0 up to ceil(MAX_PAGES/8), 512 with defaults) before the result is queued in ST_FIN.
// Each word is read from the bitmap RAM in ST_RD, then evaluated and written back in ST_EVAL.
// One request is handled at a time; the next request is taken once the
// result is queued. Reset: asynchronous, active low; afterwards a clearing pass zeroes all
// ceil(MAX_PAGES/8) bitmap words (512 with defaults), during which no request is accepted.
module page_frame_bitmap_allocator_top #(
	parameter int MAX_PAGES = pfba_pkg::MAX_PAGES_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pfba_pkg::COUNT_W-1:0]     page_count,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             action,
	input  logic [pfba_pkg::ADDR_W-1:0]      start_address,
	input  logic [pfba_pkg::ADDR_W-1:0]      length_bytes,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             success,
	output logic [pfba_pkg::ADDR_W-1:0]      frame_address
);

	localparam int BPW = pfba_pkg::BITS_PER_WORD;
	localparam int BIT_W = pfba_pkg::BIT_W;
	localparam int WORD_COUNT = (MAX_PAGES + BPW - 1) / BPW;
	localparam int FRAME_W = ($clog2(MAX_PAGES) > BIT_W) ? $clog2(MAX_PAGES) : BIT_W + 1;
	localparam int WADDR_W = FRAME_W - BIT_W;
	localparam int PAGE_W = $clog2(MAX_PAGES + 1);
	localparam int SPG_W = pfba_pkg::ADDR_W - pfba_pkg::PAGE_SHIFT;
	localparam int SUM_W = pfba_pkg::ADDR_W + 2;
	localparam int EPG_W = SUM_W - pfba_pkg::PAGE_SHIFT;
	localparam int CMP_W = (PAGE_W > EPG_W) ? PAGE_W : EPG_W;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PREP,
		ST_RD,
		ST_EVAL,
		ST_FIN
	} state_t;

	state_t                           state_q;
	logic [pfba_pkg::COUNT_W-1:0]     page_count_q;
	logic                             act_q;
	logic [SPG_W-1:0]                 spg_q;
	logic [EPG_W-1:0]                 epg_q;
	logic [FRAME_W-1:0]               lo_q;
	logic [FRAME_W-1:0]               hi_q;
	logic [WADDR_W-1:0]               w_q;
	logic                             res_succ_q;
	logic [pfba_pkg::ADDR_W-1:0]      res_addr_q;
	logic                             out_valid_q;
	logic                             success_q;
	logic [pfba_pkg::ADDR_W-1:0]      frame_address_q;

	logic [CMP_W-1:0]                 n_c;
	logic [CMP_W-1:0]                 lim_c;
	logic [FRAME_W-1:0]               lo_d;
	logic [FRAME_W-1:0]               hi_d;
	logic                             prep_done;
	logic                             prep_succ;
	logic                             last_word;
	logic [BIT_W-1:0]                 lo_bit;
	logic [BIT_W-1:0]                 hi_bit;
	pfba_pkg::word_t                  mask;
	pfba_pkg::word_t                  free_bits;
	pfba_pkg::word_t                  onehot;
	logic [BIT_W-1:0]                 sel_bit;
	logic                             found;
	logic [FRAME_W-1:0]               frame_c;
	logic [SUM_W-1:0]                 end_sum;

	logic                             ram_we;
	logic [WADDR_W-1:0]               ram_waddr;
	pfba_pkg::word_t                  ram_wdata;
	logic                             ram_re;
	pfba_pkg::word_t                  ram_rdata;

	pfba_bitmap_ram #(
		.DEPTH (WORD_COUNT),
		.AW    (WADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (w_q),
		.rdata (ram_rdata)
	);

	// Configuration register, always writable.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_count_q <= pfba_pkg::PAGE_COUNT_RESET;
		end else if (cfg_valid) begin
			page_count_q <= page_count;
		end
	end

	// Managed page count, clipped to the size of the bitmap.
	assign n_c = (CMP_W'(page_count_q) > CMP_W'(MAX_PAGES)) ? CMP_W'(MAX_PAGES)
		: CMP_W'(page_count_q);

	// Reserve range end page, clipped to the managed page count.
	assign lim_c = (CMP_W'(epg_q) > n_c) ? n_c : CMP_W'(epg_q);

	// Rounded-up end page of a reserve request, formed without wrap.
	assign end_sum = SUM_W'(start_address) + SUM_W'(length_bytes)
		+ SUM_W'(pfba_pkg::PAGE_BYTES - 1);

	// Frame range that the word loop walks.
	always_comb begin
		lo_d = '0;
		hi_d = '0;
		prep_done = 1'b0;
		prep_succ = 1'b0;
		if (!act_q) begin
			hi_d = FRAME_W'(n_c - CMP_W'(1));
			prep_done = (n_c == '0);
		end else begin
			lo_d = FRAME_W'(spg_q);
			hi_d = FRAME_W'(lim_c - CMP_W'(1));
			prep_done = (CMP_W'(spg_q) >= lim_c);
			prep_succ = 1'b1;
		end
	end

	// Bit mask of the current word that falls inside the range, and the lowest free bit.
	assign last_word = (w_q == hi_q[FRAME_W-1:BIT_W]);

	always_comb begin
		lo_bit = (w_q == lo_q[FRAME_W-1:BIT_W]) ? lo_q[BIT_W-1:0] : '0;
		hi_bit = last_word ? hi_q[BIT_W-1:0] : '1;
		for (int b = 0; b < BPW; b++) begin
			mask[b] = (BIT_W'(b) >= lo_bit) && (BIT_W'(b) <= hi_bit);
		end
		free_bits = ~ram_rdata & mask;
		found = |free_bits;
		sel_bit = '0;
		for (int b = BPW - 1; b >= 0; b--) begin
			if (free_bits[b]) begin
				sel_bit = BIT_W'(b);
			end
		end
		onehot = pfba_pkg::word_t'(1) << sel_bit;
	end

	assign frame_c = {w_q, sel_bit};

	// Bitmap RAM port: clearing pass, or write-back of the evaluated word.
	always_comb begin
		ram_we = 1'b0;
		ram_wdata = '0;
		ram_waddr = w_q;
		ram_re = (state_q == ST_RD);
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_EVAL: begin
				if (act_q) begin
					ram_we = 1'b1;
					ram_wdata = ram_rdata | mask;
				end else begin
					ram_we = found;
					ram_wdata = ram_rdata | onehot;
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			w_q <= '0;
			act_q <= 1'b0;
			spg_q <= '0;
			epg_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			res_succ_q <= 1'b0;
			res_addr_q <= '0;
			out_valid_q <= 1'b0;
			success_q <= 1'b0;
			frame_address_q <= '0;
		end else begin
			// A taken result frees the output register; the final state refills it itself.
			if (out_valid_q && out_ready && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					w_q <= w_q + WADDR_W'(1);
					if (w_q == WADDR_W'(WORD_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						act_q <= action;
						spg_q <= start_address[pfba_pkg::ADDR_W-1:pfba_pkg::PAGE_SHIFT];
						epg_q <= end_sum[SUM_W-1:pfba_pkg::PAGE_SHIFT];
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					lo_q <= lo_d;
					hi_q <= hi_d;
					w_q <= lo_d[FRAME_W-1:BIT_W];
					if (prep_done) begin
						res_succ_q <= prep_succ;
						res_addr_q <= '0;
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (act_q) begin
						res_succ_q <= 1'b1;
						res_addr_q <= '0;
						if (last_word) begin
							state_q <= ST_FIN;
						end else begin
							w_q <= w_q + WADDR_W'(1);
							state_q <= ST_RD;
						end
					end else if (found) begin
						res_succ_q <= 1'b1;
						res_addr_q <= pfba_pkg::ADDR_W'(frame_c) << pfba_pkg::PAGE_SHIFT;
						state_q <= ST_FIN;
					end else if (last_word) begin
						res_succ_q <= 1'b0;
						res_addr_q <= '0;
						state_q <= ST_FIN;
					end else begin
						w_q <= w_q + WADDR_W'(1);
						state_q <= ST_RD;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						success_q <= res_succ_q;
						frame_address_q <= res_addr_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign success = success_q;
	assign frame_address = frame_address_q;

endmodule

@@ src/pfba_checker.sv @@
module pfba_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic                             success,
	input logic [pfba_pkg::ADDR_W-1:0]      frame_address
);

	// A held result does not change until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(success) && $stable(frame_address))
		else $error("result changed while stalled");

	// A failed request reports address zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !success |-> frame_address == '0)
		else $error("failed request with nonzero address");

	// Every reported address lies on a page boundary.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> frame_address[pfba_pkg::PAGE_SHIFT-1:0] == '0)
		else $error("frame address not page aligned");

	// One request at a time: the block is busy right after taking a request.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while busy");

endmodule

bind page_frame_bitmap_allocator_top pfba_checker u_pfba_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.success       (success),
	.frame_address (frame_address)
);

@@ test/page_frame_bitmap_allocator_top_tb.sv @@
module page_frame_bitmap_allocator_top_tb;

	import pfba_pkg::*;

	localparam int FRAME_LIMIT = MAX_PAGES_DEFAULT;
	localparam int WATCHDOG_LIMIT = 8000;
	localparam int REPORT_LIMIT = 10;

	typedef enum logic {ACT_ALLOC = 1'b0, ACT_RESERVE = 1'b1} action_e;
	typedef enum logic {ROW_REQUEST = 1'b0, ROW_SET_COUNT = 1'b1} row_kind_e;

	typedef struct packed {
		action_e           action;
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] len;
	} request_t;

	typedef struct packed {
		logic              success;
		logic [ADDR_W-1:0] frame_address;
	} outcome_t;

	typedef struct packed {
		row_kind_e          kind;
		request_t           req;
		logic [COUNT_W-1:0] count;
		bit                 known;
		outcome_t           want;
	} row_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [COUNT_W-1:0]  page_count;
	logic                in_valid;
	logic                in_ready;
	logic                action;
	logic [ADDR_W-1:0]   start_address;
	logic [ADDR_W-1:0]   length_bytes;
	logic                out_valid;
	logic                out_ready;
	logic                success;
	logic [ADDR_W-1:0]   frame_address;

	// Predictor state: one flag per frame plus the page count register.
	bit                 frame_used [FRAME_LIMIT];
	logic [COUNT_W-1:0] model_page_count;

	outcome_t awaited_results [$];
	row_t     directed_rows [$];
	row_t     closing_rows [$];

	int send_idle_pct;
	int recv_idle_pct;
	int error_count;
	int idle_cycles;
	int alloc_count;
	int reserve_count;
	int granted_count;
	int refused_count;
	int count_settings;

	page_frame_bitmap_allocator_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.page_count    (page_count),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.start_address (start_address),
		.length_bytes  (length_bytes),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.success       (success),
		.frame_address (frame_address)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void note_failure(string msg);
		error_count++;
		if (error_count <= REPORT_LIMIT) begin
			$display("%s", msg);
		end
	endfunction

	function automatic int unsigned managed_frames();
		return (model_page_count > FRAME_LIMIT) ? FRAME_LIMIT : int'(model_page_count);
	endfunction

	// Apply one request to the frame map and return the result it should give.
	function automatic outcome_t update_frame_map(request_t r);
		outcome_t          res;
		int unsigned       managed;
		longint unsigned   range_end;
		longint unsigned   first_page;
		longint unsigned   end_page;
		managed = managed_frames();
		res = '{success: 1'b0, frame_address: '0};
		if (r.action == ACT_ALLOC) begin
			for (int p = 0; p < managed; p++) begin
				if (!frame_used[p]) begin
					frame_used[p] = 1'b1;
					res.success = 1'b1;
					res.frame_address = ADDR_W'(longint'(p) * PAGE_BYTES);
					break;
				end
			end
		end else begin
			// The range end is formed wider than the address, so it never wraps.
			range_end = {32'd0, r.start} + {32'd0, r.len};
			first_page = {32'd0, r.start} >> PAGE_SHIFT;
			end_page = (range_end + PAGE_BYTES - 1) >> PAGE_SHIFT;
			if (end_page > managed) begin
				end_page = managed;
			end
			for (longint unsigned p = first_page; p < end_page; p++) begin
				frame_used[p] = 1'b1;
			end
			res.success = 1'b1;
		end
		return res;
	endfunction

	function automatic row_t req_row(action_e a, logic [ADDR_W-1:0] s, logic [ADDR_W-1:0] l);
		return '{kind: ROW_REQUEST, req: '{action: a, start: s, len: l}, count: '0,
			known: 1'b0, want: '0};
	endfunction

	function automatic row_t known_row(action_e a, logic [ADDR_W-1:0] s, logic [ADDR_W-1:0] l,
			logic ok, logic [ADDR_W-1:0] addr);
		return '{kind: ROW_REQUEST, req: '{action: a, start: s, len: l}, count: '0,
			known: 1'b1, want: '{success: ok, frame_address: addr}};
	endfunction

	function automatic row_t count_row(logic [COUNT_W-1:0] v);
		return '{kind: ROW_SET_COUNT, req: '0, count: v, known: 1'b0, want: '0};
	endfunction

	// Mostly allocations and short reserves near the managed frames, some far-off noise.
	function automatic request_t random_request();
		request_t    r;
		int unsigned managed;
		int unsigned pick;
		int unsigned first_page;
		int unsigned span;
		managed = managed_frames();
		pick = $urandom_range(0, 99);
		r.start = $urandom;
		r.len = $urandom;
		if (pick < 55) begin
			r.action = ACT_ALLOC;
		end else begin
			r.action = ACT_RESERVE;
			if (pick < 88) begin
				first_page = $urandom_range(0, managed + 3);
				r.start = ADDR_W'(first_page) << PAGE_SHIFT;
				if ($urandom_range(0, 1) == 1) begin
					r.start += $urandom_range(0, PAGE_BYTES - 1);
				end
				span = $urandom_range(0, 9);
				if (span == 0) begin
					r.len = '0;
				end else if (span < 8) begin
					r.len = $urandom_range(1, 3 * PAGE_BYTES);
				end else begin
					r.len = $urandom_range(1, 16 * PAGE_BYTES);
				end
			end else if (r.start < 32'h0100_0000) begin
				// Keep noise above the managed space so it cannot swallow the map.
				r.start += 32'h0100_0000;
			end
		end
		return r;
	endfunction

	// Hold requests back until every pending result has been taken.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (awaited_results.size() != 0);
	endtask

	// Present one request, wait for the handshake and queue what it should return.
	task automatic issue_request(request_t r, bit known, outcome_t want);
		outcome_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= r.action;
		start_address <= r.start;
		length_bytes <= r.len;
		do @(posedge clk); while (in_ready !== 1'b1);
		predicted = update_frame_map(r);
		if (known) begin
			predicted = want;
		end
		awaited_results.push_back(predicted);
		if (r.action == ACT_ALLOC) begin
			alloc_count++;
			if (predicted.success) begin
				granted_count++;
			end else begin
				refused_count++;
			end
		end else begin
			reserve_count++;
		end
		@(negedge clk);
	endtask

	task automatic write_page_count(logic [COUNT_W-1:0] v);
		drain_results();
		cfg_valid <= 1'b1;
		page_count <= v;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		model_page_count = v;
		count_settings++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_rows(row_t rows [$]);
		foreach (rows[i]) begin
			if (rows[i].kind == ROW_SET_COUNT) begin
				write_page_count(rows[i].count);
			end else begin
				issue_request(rows[i].req, rows[i].known, rows[i].want);
			end
		end
	endtask

	task automatic run_random(int count);
		repeat (count) begin
			if ($urandom_range(0, 99) < 3) begin
				drain_results();
			end
			issue_request(random_request(), 1'b0, '0);
		end
	endtask

	// The receiver stalls at random at the current rate.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Result checker and watchdog.
	always @(posedge clk) begin
		outcome_t exp_res;
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no handshake for %0d cycles, %0d results pending",
				idle_cycles, awaited_results.size());
			$display("page_frame_bitmap_allocator_top_tb: done, errors");
			$finish;
		end else if (arst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (awaited_results.size() == 0) begin
				note_failure($sformatf("unexpected result: success=%0b frame_address=%h",
					success, frame_address));
			end else begin
				exp_res = awaited_results.pop_front();
				if (success !== exp_res.success) begin
					note_failure($sformatf("success mismatch: expected %0b, got %0b",
						exp_res.success, success));
				end
				if (frame_address !== exp_res.frame_address) begin
					note_failure($sformatf("frame_address mismatch: expected %h, got %h",
						exp_res.frame_address, frame_address));
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		page_count = '0;
		in_valid = 1'b0;
		action = ACT_ALLOC;
		start_address = '0;
		length_bytes = '0;
		out_ready = 1'b0;
		send_idle_pct = 34;
		recv_idle_pct = 47;
		error_count = 0;
		idle_cycles = 0;
		alloc_count = 0;
		reserve_count = 0;
		granted_count = 0;
		refused_count = 0;
		count_settings = 0;
		model_page_count = PAGE_COUNT_RESET;
		foreach (frame_used[i]) begin
			frame_used[i] = 1'b0;
		end

		// Directed requests: reset state, field extremes and the corner cases.
		directed_rows = '{
			known_row(ACT_ALLOC, 32'h0, 32'h0, 1'b1, 32'h0000_0000),
			// Address and length are ignored on allocate.
			known_row(ACT_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_1000),
			// Zero length at an aligned start marks nothing.
			known_row(ACT_RESERVE, 32'h0, 32'h0, 1'b1, 32'h0),
			// Zero length at an unaligned start marks the page holding it.
			known_row(ACT_RESERVE, 32'h0000_2001, 32'h0, 1'b1, 32'h0),
			req_row(ACT_ALLOC, 32'h0, 32'h0),
			req_row(ACT_RESERVE, 32'h0000_5000, 32'h0000_3000),
			req_row(ACT_RESERVE, 32'h0000_9FFF, 32'h0000_0002),
			req_row(ACT_ALLOC, 32'h0, 32'h0),
			req_row(ACT_ALLOC, 32'h0, 32'h0),
			// Range end beyond 32 bits must not wrap back to low pages.
			known_row(ACT_RESERVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0),
			known_row(ACT_RESERVE, 32'hFFFF_F000, 32'h0000_1000, 1'b1, 32'h0),
			// With no frames managed, allocate fails and reserve changes nothing.
			count_row(13'd0),
			known_row(ACT_ALLOC, 32'h0, 32'h0, 1'b0, 32'h0),
			known_row(ACT_RESERVE, 32'h0, 32'hFFFF_FFFF, 1'b1, 32'h0),
			// One frame, already taken.
			count_row(13'd1),
			known_row(ACT_ALLOC, 32'h0, 32'h0, 1'b0, 32'h0),
			// Reserve clipped at the page count, then the pool is empty.
			count_row(13'd16),
			req_row(ACT_ALLOC, 32'h0, 32'h0),
			req_row(ACT_RESERVE, 32'h0000_C000, 32'h0001_0000),
			req_row(ACT_ALLOC, 32'h0, 32'h0),
			// Count above the frame limit manages every frame.
			count_row(13'h1FFF),
			req_row(ACT_ALLOC, 32'h0, 32'h0),
			req_row(ACT_RESERVE, 32'h00FF_F000, 32'h0000_1000),
			req_row(ACT_ALLOC, 32'h0, 32'h0)
		};

		// Fill the whole map, then allocation must fail at every count.
		closing_rows = '{
			count_row(13'd4096),
			known_row(ACT_RESERVE, 32'h0, 32'hFFFF_FFFF, 1'b1, 32'h0),
			known_row(ACT_ALLOC, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, 32'h0),
			count_row(13'h1FFF),
			known_row(ACT_ALLOC, 32'h0, 32'h0, 1'b0, 32'h0)
		};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_rows(directed_rows);

		// Random requests over several page counts and stall patterns.
		write_page_count(13'd4096);
		run_random(300);

		send_idle_pct = 47;
		recv_idle_pct = 34;
		write_page_count(13'd40);
		run_random(200);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_page_count(13'h1FFF);
		run_random(250);

		repeat (6) begin
			write_page_count(COUNT_W'($urandom_range(0, 13'h1FFF)));
			run_random(50);
		end

		run_rows(closing_rows);

		// Let any stray result show up before the final tally.
		drain_results();
		repeat (64) @(negedge clk);
		while (awaited_results.size() != 0) begin
			void'(awaited_results.pop_front());
			note_failure("expected result never arrived");
		end

		$display("Covered %0d allocate and %0d reserve requests over %0d page count settings.",
			alloc_count, reserve_count, count_settings);
		$display("Allocations granted: %0d, refused: %0d; mismatches: %0d.",
			granted_count, refused_count, error_count);
		if (error_count == 0) begin
			$display("page_frame_bitmap_allocator_top_tb: done, clean");
		end else begin
			$display("page_frame_bitmap_allocator_top_tb: done, errors");
		end
		$finish;
	end

endmodule

@@ page_frame_bitmap_allocator_top.f @@
src/pfba_pkg.sv
src/pfba_bitmap_ram.sv
src/page_frame_bitmap_allocator_top.sv
src/pfba_checker.sv
test/page_frame_bitmap_allocator_top_tb.sv
